// ===== rtl/miu_pkg.sv =====
// shared types and constants for the mips integer execute unit
`default_nettype none
package miu_pkg;
   localparam logic [31:0] REGION_MASK = 32'hF000_0000;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;

   // special function codes
   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_SRLV  = 6'h06;
   localparam logic [5:0] FN_SRAV  = 6'h07;
   localparam logic [5:0] FN_JR    = 6'h08;
   localparam logic [5:0] FN_JALR  = 6'h09;
   localparam logic [5:0] FN_MFHI  = 6'h10;
   localparam logic [5:0] FN_MTHI  = 6'h11;
   localparam logic [5:0] FN_MFLO  = 6'h12;
   localparam logic [5:0] FN_MTLO  = 6'h13;
   localparam logic [5:0] FN_MULT  = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV   = 6'h1A;
   localparam logic [5:0] FN_DIVU  = 6'h1B;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_XOR   = 6'h26;
   localparam logic [5:0] FN_NOR   = 6'h27;
   localparam logic [5:0] FN_SLT   = 6'h2A;
   localparam logic [5:0] FN_SLTU  = 6'h2B;

   // regimm rt codes
   localparam logic [4:0] RT_BLTZ   = 5'h00;
   localparam logic [4:0] RT_BGEZ   = 5'h01;
   localparam logic [4:0] RT_BLTZAL = 5'h10;
   localparam logic [4:0] RT_BGEZAL = 5'h11;

   localparam logic [4:0] LINK_REG = 5'd31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_MDU,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture the item
      logic exec;      // evaluate, and commit ops other than multiply and divide
      logic mdu_start; // launch multiply or divide
      logic mdu_step;  // iterate the shared unit
      logic mdu_end;   // commit hi and lo
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_mdu;
      logic mdu_last;
   } status_type;
endpackage
`default_nettype wire

// ===== rtl/miu_ctrl.sv =====
// sequencing controller of the execute unit
`default_nettype none
module miu_ctrl
   import miu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cmd_type         cmd,
   input  wire status_type status
);
   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.is_mdu) begin
               cmd.mdu_start = 1'b1;
               state_in = ST_MDU;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MDU: begin
            cmd.mdu_step = 1'b1;
            if (status.mdu_last) begin
               cmd.mdu_end = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/miu_mdu.sv =====
// iterative multiply and divide unit, one bit per cycle while step is high
`default_nettype none
module miu_mdu
   import miu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        step,
   input  wire logic        is_div,
   input  wire logic        is_signed,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic             last,
   output logic [31:0]      hi_result,
   output logic [31:0]      lo_result
);
   logic [4:0]  count_ff;
   logic        div_ff, neg_q_ff, neg_r_ff, zero_ff;
   logic [31:0] mag_b_ff;   // divisor magnitude or multiplicand
   logic [31:0] acc_ff;     // remainder or product high
   logic [31:0] lo_ff;      // quotient or product low
   logic [31:0] mag_a, mag_b;
   logic        neg_a, neg_b;
   logic [32:0] trial, madd;
   logic [31:0] q_fin, r_fin;

   assign neg_a = is_signed & op_a[31];
   assign neg_b = is_signed & op_b[31];
   assign mag_a = neg_a ? (32'd0 - op_a) : op_a;
   assign mag_b = neg_b ? (32'd0 - op_b) : op_b;

   // one restoring division step and one shift-add step
   assign trial = {acc_ff, lo_ff[31]} - {1'b0, mag_b_ff};
   assign madd  = {1'b0, acc_ff} + (lo_ff[0] ? {1'b0, mag_b_ff} : 33'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff   <= is_div;
         neg_q_ff <= neg_a ^ neg_b;
         neg_r_ff <= neg_a;
         zero_ff  <= (op_b == 32'd0);
         mag_b_ff <= mag_b;
         acc_ff   <= '0;
         lo_ff    <= mag_a;
      end else if (step) begin
         if (div_ff) begin
            if (!trial[32]) begin
               acc_ff <= trial[31:0];
               lo_ff  <= {lo_ff[30:0], 1'b1};
            end else begin
               acc_ff <= {acc_ff[30:0], lo_ff[31]};
               lo_ff  <= {lo_ff[30:0], 1'b0};
            end
         end else begin
            acc_ff <= madd[32:1];
            lo_ff  <= {madd[0], lo_ff[31:1]};
         end
      end
   end

   assign last = (count_ff == 5'd31);

   // sign fixup, valid on the cycle after the last step
   assign q_fin = neg_q_ff ? (32'd0 - lo_ff) : lo_ff;
   assign r_fin = neg_r_ff ? (32'd0 - acc_ff) : acc_ff;
   always_comb begin
      if (!div_ff) begin
         if (neg_q_ff) begin
            {hi_result, lo_result} = 64'd0 - {acc_ff, lo_ff};
         end else begin
            {hi_result, lo_result} = {acc_ff, lo_ff};
         end
      end else if (zero_ff) begin
         hi_result = '0;
         lo_result = '0;
      end else begin
         hi_result = r_fin;
         lo_result = q_fin;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/miu_dpath.sv =====
// datapath: register file, alu, branch evaluation and hi/lo
`default_nettype none
module miu_dpath
   import miu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [31:0] req_instr_word,
   input  wire logic [31:0] req_slot_address,
   output logic             rsp_reg_write,
   output logic [4:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic             rsp_taken,
   output logic [31:0]      rsp_branch_target,
   output logic             rsp_unsupported
);
   logic [31:0] gpr_mem [32];
   logic [31:0] instr_ff, slot_ff, a_ff, b_ff, hi_ff, lo_ff;
   logic        mdu_pend_ff;
   logic        wr_ff, tk_ff, un_ff;
   logic [4:0]  di_ff;
   logic [31:0] dv_ff, ta_ff;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [15:0] imm;
   logic [31:0] simm, zimm, branch_to, jump_to, link, a, b;
   logic        wr, tk, un, hi_we, lo_we, mdu_go, mdu_div, mdu_sgn;
   logic [4:0]  di;
   logic [31:0] dv, ta;
   logic        mdu_last;
   logic [31:0] mdu_hi, mdu_lo;

   assign op  = instr_ff[31:26];
   assign rs  = instr_ff[25:21];
   assign rt  = instr_ff[20:16];
   assign rd  = instr_ff[15:11];
   assign sh  = instr_ff[10:6];
   assign fn  = instr_ff[5:0];
   assign imm = instr_ff[15:0];
   assign simm = {{16{imm[15]}}, imm};
   assign zimm = {16'd0, imm};
   assign branch_to = slot_ff + {simm[29:0], 2'b00};
   assign jump_to   = (slot_ff & REGION_MASK) | {4'd0, instr_ff[25:0], 2'b00};
   assign link      = slot_ff + 32'd4;
   assign a = a_ff;
   assign b = b_ff;

   // item capture and operand read
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         instr_ff <= req_instr_word;
         slot_ff  <= req_slot_address;
      end
      a_ff <= (rs == 5'd0) ? 32'd0 : gpr_mem[rs];
      b_ff <= (rt == 5'd0) ? 32'd0 : gpr_mem[rt];
   end

   // decode and evaluate
   always_comb begin
      wr = 1'b0; tk = 1'b0; un = 1'b0; di = '0; dv = '0; ta = '0;
      hi_we = 1'b0; lo_we = 1'b0; mdu_go = 1'b0; mdu_div = 1'b0; mdu_sgn = 1'b0;
      unique case (op)
         OP_SPECIAL: begin
            di = rd;
            unique case (fn)
               FN_SLL:  begin wr = 1'b1; dv = b << sh; end
               FN_SRL:  begin wr = 1'b1; dv = b >> sh; end
               FN_SRA:  begin wr = 1'b1; dv = $unsigned($signed(b) >>> sh); end
               FN_SLLV: begin wr = 1'b1; dv = b << a[4:0]; end
               FN_SRLV: begin wr = 1'b1; dv = b >> a[4:0]; end
               FN_SRAV: begin wr = 1'b1; dv = $unsigned($signed(b) >>> a[4:0]); end
               FN_JR:   begin tk = 1'b1; ta = a; end
               FN_JALR: begin tk = 1'b1; ta = a; wr = 1'b1; dv = link; end
               FN_MFHI: begin wr = 1'b1; dv = hi_ff; end
               FN_MTHI: hi_we = 1'b1;
               FN_MFLO: begin wr = 1'b1; dv = lo_ff; end
               FN_MTLO: lo_we = 1'b1;
               FN_MULT:  begin mdu_go = 1'b1; mdu_sgn = 1'b1; end
               FN_MULTU: mdu_go = 1'b1;
               FN_DIV:   begin mdu_go = 1'b1; mdu_div = 1'b1; mdu_sgn = 1'b1; end
               FN_DIVU:  begin mdu_go = 1'b1; mdu_div = 1'b1; end
               FN_ADD, FN_ADDU: begin wr = 1'b1; dv = a + b; end
               FN_SUB, FN_SUBU: begin wr = 1'b1; dv = a - b; end
               FN_AND:  begin wr = 1'b1; dv = a & b; end
               FN_OR:   begin wr = 1'b1; dv = a | b; end
               FN_XOR:  begin wr = 1'b1; dv = a ^ b; end
               FN_NOR:  begin wr = 1'b1; dv = ~(a | b); end
               FN_SLT:  begin wr = 1'b1; dv = {31'd0, $signed(a) < $signed(b)}; end
               FN_SLTU: begin wr = 1'b1; dv = {31'd0, a < b}; end
               default: un = 1'b1;
            endcase
         end
         OP_REGIMM: begin
            unique case (rt)
               RT_BLTZ: tk = a[31];
               RT_BGEZ: tk = !a[31];
               RT_BLTZAL: begin tk = a[31]; wr = 1'b1; di = LINK_REG; dv = link; end
               RT_BGEZAL: begin tk = !a[31]; wr = 1'b1; di = LINK_REG; dv = link; end
               default: un = 1'b1;
            endcase
            if (tk) ta = branch_to;
         end
         OP_J:   begin tk = 1'b1; ta = jump_to; end
         OP_JAL: begin tk = 1'b1; ta = jump_to; wr = 1'b1; di = LINK_REG; dv = link; end
         OP_BEQ:  begin tk = (a == b); if (tk) ta = branch_to; end
         OP_BNE:  begin tk = (a != b); if (tk) ta = branch_to; end
         OP_BLEZ: begin tk = a[31] || (a == 32'd0); if (tk) ta = branch_to; end
         OP_BGTZ: begin tk = !a[31] && (a != 32'd0); if (tk) ta = branch_to; end
         OP_ADDI, OP_ADDIU: begin wr = 1'b1; di = rt; dv = a + simm; end
         OP_SLTI:  begin wr = 1'b1; di = rt; dv = {31'd0, $signed(a) < $signed(simm)}; end
         OP_SLTIU: begin wr = 1'b1; di = rt; dv = {31'd0, a < simm}; end
         OP_ANDI:  begin wr = 1'b1; di = rt; dv = a & zimm; end
         OP_ORI:   begin wr = 1'b1; di = rt; dv = a | zimm; end
         OP_XORI:  begin wr = 1'b1; di = rt; dv = a ^ zimm; end
         OP_LUI:   begin wr = 1'b1; di = rt; dv = {imm, 16'd0}; end
         default: un = 1'b1;
      endcase
      if (un) begin
         tk = 1'b0; ta = '0;
      end
      if (!(wr && !un && di != 5'd0)) begin
         wr = 1'b0; di = '0; dv = '0;
      end
   end

   assign status.is_mdu   = mdu_go;
   assign status.mdu_last = mdu_last;

   miu_mdu u_mdu (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mdu_start),
      .step      (cmd.mdu_step),
      .is_div    (mdu_div),
      .is_signed (mdu_sgn),
      .op_a      (a),
      .op_b      (b),
      .last      (mdu_last),
      .hi_result (mdu_hi),
      .lo_result (mdu_lo)
   );

   // hi/lo take the unit's results once mdu_pend_ff, registered from mdu_end, is set
   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff       <= '0;
         lo_ff       <= '0;
         mdu_pend_ff <= 1'b0;
      end else begin
         mdu_pend_ff <= cmd.mdu_end;
         if (mdu_pend_ff) begin
            hi_ff <= mdu_hi;
            lo_ff <= mdu_lo;
         end else if (cmd.exec) begin
            if (hi_we) hi_ff <= a;
            if (lo_we) lo_ff <= a;
         end
      end
   end

   // register file write, entry 0 never read
   always_ff @(posedge clock) begin
      if (cmd.exec && wr) begin
         gpr_mem[di] <= dv;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         wr_ff <= wr;
         di_ff <= di;
         dv_ff <= dv;
         tk_ff <= tk;
         ta_ff <= ta;
         un_ff <= un;
      end
   end

   assign rsp_reg_write     = wr_ff;
   assign rsp_dest_index    = di_ff;
   assign rsp_dest_value    = dv_ff;
   assign rsp_taken         = tk_ff;
   assign rsp_branch_target = ta_ff;
   assign rsp_unsupported   = un_ff;
endmodule
`default_nettype wire

// ===== rtl/mips_integer_execute_unit.sv =====
// top level of the mips-i integer execute unit
`default_nettype none
// Executes one MIPS-I integer instruction per item against a 32-entry register
// file and HI/LO. After reset a clearing pass writes zero to registers 1 to 31
// (register 0 always reads as zero), and no item is accepted during it. An ALU,
// shift, move or branch item passes from accept to result through the register
// read, execute and result states; multiply and divide also iterate the shared
// one-bit-per-cycle multiply/divide unit. The next item is accepted in the cycle
// its predecessor's result is taken.
module mips_integer_execute_unit
   import miu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instr_word,
   input  wire logic [31:0] req_slot_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_reg_write,
   output logic [4:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic             rsp_taken,
   output logic [31:0]      rsp_branch_target,
   output logic             rsp_unsupported
);
   cmd_type    cmd;
   status_type status;
   logic       ctl_stall, ctl_valid;
   logic [5:0] clr_ff;
   logic       clr_done_ff;
   logic       clearing;
   logic [31:0] instr_mux;

   // clearing pass: feed addiu rN, r0, 0 for every register after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
      end else if (clearing) begin
         if (cmd.exec && !clr_ff[5]) begin
            clr_ff <= clr_ff + 6'd1;
         end
         if (clr_ff[5] && ctl_valid) begin
            clr_done_ff <= 1'b1;
         end
      end
   end
   assign clearing = !clr_done_ff;

   assign instr_mux = clearing ? {OP_ADDIU, 5'd0, clr_ff[4:0], 16'd0} : req_instr_word;

   miu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (clearing ? !clr_ff[5] : req_valid),
      .req_stall (ctl_stall),
      .rsp_valid (ctl_valid),
      .rsp_stall (clearing ? 1'b0 : rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   assign req_stall = clearing ? 1'b1 : ctl_stall;
   assign rsp_valid = clearing ? 1'b0 : ctl_valid;

   miu_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_instr_word    (instr_mux),
      .req_slot_address  (req_slot_address),
      .rsp_reg_write     (rsp_reg_write),
      .rsp_dest_index    (rsp_dest_index),
      .rsp_dest_value    (rsp_dest_value),
      .rsp_taken         (rsp_taken),
      .rsp_branch_target (rsp_branch_target),
      .rsp_unsupported   (rsp_unsupported)
   );

`ifndef SYNTH
   // no item accepted while a result is waiting untaken
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("item accepted while result pending");
   // a result never appears in the cycle right after accept
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result too early");
   // no item taken during the clearing pass
   a_clear_hold: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (req_stall && !rsp_valid))
      else $error("activity during clearing");
`endif
endmodule
`default_nettype wire
